FILE: hw/rtl/box_blur_clipped_edges_macros.svh
// Assertion macros used by the box blur controller.
`ifndef BOX_BLUR_CLIPPED_EDGES_MACROS_SVH
`define BOX_BLUR_CLIPPED_EDGES_MACROS_SVH

// Implication checked at every edge outside reset.
`define BBCE_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Implication checked in the cycle after the condition.
`define BBCE_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: hw/rtl/bbce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bbce_pkg;
   localparam int MAX_RADIUS_DEF = 7;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;     // begin a beat: register the input fields
      logic clr_acc;   // clear window accumulators
      logic rd_issue;  // issue one window read
      logic acc_en;    // accumulate registered read data
      logic div_start; // start the three divisions
      logic finish;    // latch the result and update counters
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit;      // this beat produces a result
      logic win_done;  // last window read is issued this cycle, or the window is empty
      logic div_done;  // divider finished
   } sts_type;
endpackage
`default_nettype wire

FILE: hw/rtl/bbce_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_clipped_edges_macros.svh"
module bbce_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output bbce_pkg::cmd_type      cmd,
   input  wire bbce_pkg::sts_type sts
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC  = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_ACC  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_WDIV = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       take;

   assign take       = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      cmd          = '0;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd.start = 1'b1;
               state_in  = S_DEC;
            end
         end
         S_DEC: begin
            if (sts.emit) begin
               cmd.clr_acc = 1'b1;
               state_in    = S_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RD: begin
            cmd.rd_issue = 1'b1;
            if (sts.win_done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_WDIV;
         end
         S_WDIV: begin
            if (sts.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.finish   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // Read data lands in the cycle after its issue; accumulate it in both states.
      cmd.acc_en = (state_ff == S_RD) || (state_ff == S_ACC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `BBCE_ASSERT_NEXT(a_start_dec, clock, reset, take, state_ff == S_DEC, "start not decoded")
   `BBCE_ASSERT_IMP(a_busy_nready, clock, reset, state_ff != S_IDLE, !req_tready,
      "ready while busy")
   `BBCE_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp_tvalid,
      "result not shown")
endmodule
`default_nettype wire

FILE: hw/rtl/bbce_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bbce_div #(
   parameter int NW = 20,
   parameter int DW = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic [NW-1:0]      quo,
   output logic               done
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW:0]   trial;

   assign quo  = q_ff;
   assign done = busy_ff && (cnt_ff == CW'(0));

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in    = num;
         rem_in  = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff != CW'(0)) begin
         cnt_in = cnt_ff - CW'(1);
         if (trial >= {1'b0, den}) begin
            rem_in = trial - {1'b0, den};
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/bbce_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module bbce_datapath #(
   parameter int MAX_RADIUS = bbce_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = bbce_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bbce_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bbce_pkg::cmd_type cmd,
   output bbce_pkg::sts_type      sts,
   input  wire logic              in_op,
   input  wire logic [23:0]       in_px,
   input  wire logic [4:0]        radius,
   input  wire logic [13:0]       width,
   input  wire logic [14:0]       height,
   output logic [24:0]            rsp_data
);
   localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT + 1);
   localparam int LW    = CW + RW + 1;
   localparam int NCNT  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int KW    = $clog2(NCNT + 1);
   localparam int SW    = KW + 8;
   localparam int PW    = AW + 1;

   logic [23:0] mem [DEPTH];
   logic [CW-1:0] icol_ff, icol_in, ocol_ff, ocol_in;
   logic [RW-1:0] irow_ff, irow_in, orow_ff, orow_in;
   logic          done_ff, done_in;
   logic          op_ff;
   logic [23:0]   px_ff;
   logic [CW-1:0] wcol;
   logic [RW-1:0] hrow;
   logic [CW:0]   x0_ff, x1_ff, x_ff;
   logic [RW:0]   y1_ff, y_ff;
   logic [AW-1:0] rowbase_ff, addr_ff;
   logic          rd_v_ff;
   logic [23:0]   rd_ff;
   logic [SW-1:0] sr_ff, sg_ff, sb_ff;
   logic [KW-1:0] cnt_ff;
   logic          last_ff;
   logic [7:0]    qr, qg, qb;
   logic [SW-1:0] q0, q1, q2;
   logic          d0, d1, d2;

   assign wcol = width[CW-1:0];
   assign hrow = height[RW-1:0];

   // Input bookkeeping and lag test, done while st_ff is set, from the registered input.
   logic          cmp_done;
   logic [LW-1:0] recv, prod;
   logic [CW-1:0] ic_n;
   logic [RW-1:0] ir_n;
   logic          wr_en;
   always_comb begin
      cmp_done = done_ff || (irow_ff >= hrow);
      ic_n     = icol_ff;
      ir_n     = irow_ff;
      wr_en    = !cmp_done && (op_ff == bbce_pkg::OP_PIXEL);
      if (wr_en) begin
         ic_n = icol_ff + CW'(1);
         if (ic_n >= wcol) begin
            ic_n = '0;
            ir_n = irow_ff + RW'(1);
         end
      end
      recv = LW'(ir_n) * LW'(wcol) + LW'(ic_n);
      prod = LW'(orow_ff) * LW'(wcol) + LW'(ocol_ff) + LW'(radius) * LW'(wcol)
             + LW'(radius) + LW'(1);
   end

   // The row ring address is advanced incrementally modulo the depth.
   function automatic logic [AW-1:0] wrap(input logic [PW-1:0] v);
      if (v >= PW'(DEPTH)) return AW'(v - PW'(DEPTH));
      return AW'(v);
   endfunction

   logic [AW-1:0] waddr_ff, waddr_in, obase_ff;
   logic          st_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff <= in_op;
         px_ff <= in_px;
      end
      st_ff <= cmd.start;
      if (st_ff && wr_en) mem[waddr_ff] <= px_ff;
      if (rd_v_ff || cmd.rd_issue) rd_ff <= mem[addr_ff];
   end

   logic         emit_c, done_c;
   always_comb begin
      done_c   = cmp_done || (ir_n >= hrow);
      emit_c   = done_c || (recv >= prod);
      waddr_in = waddr_ff;
      if (wr_en) waddr_in = wrap(PW'(waddr_ff) + PW'(1));
   end

   // Window bounds relative to the output pixel.
   logic [CW:0] x0_c, x1_c;
   logic [RW:0] y0_c, y1_c;
   logic [AW-1:0] rb_c;
   logic [PW+RW:0] back;
   always_comb begin
      x0_c = ({1'b0, ocol_ff} >= (CW+1)'(radius)) ? {1'b0, ocol_ff} - (CW+1)'(radius) : '0;
      x1_c = (({1'b0, ocol_ff} + (CW+1)'(radius)) > (CW+1)'(wcol) - (CW+1)'(1))
             ? (CW+1)'(wcol) - (CW+1)'(1) : {1'b0, ocol_ff} + (CW+1)'(radius);
      y0_c = ({1'b0, orow_ff} >= (RW+1)'(radius)) ? {1'b0, orow_ff} - (RW+1)'(radius) : '0;
      y1_c = (({1'b0, orow_ff} + (RW+1)'(radius)) > (RW+1)'(hrow) - (RW+1)'(1))
             ? (RW+1)'(hrow) - (RW+1)'(1) : {1'b0, orow_ff} + (RW+1)'(radius);
      // Ring offset of row y0 relative to the output row start.
      back = (PW+RW+1)'(({1'b0, orow_ff} - y0_c)) * (PW+RW+1)'(wcol);
      rb_c = wrap(PW'(obase_ff) + PW'(DEPTH) - PW'(back));
   end

   logic [AW-1:0] next_addr;
   always_comb begin
      next_addr = wrap(PW'(addr_ff) + PW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         icol_ff <= '0; irow_ff <= '0; ocol_ff <= '0; orow_ff <= '0;
         done_ff <= 1'b0; waddr_ff <= '0; obase_ff <= '0;
         rd_v_ff <= 1'b0;
      end else begin
         // Every issued read, the last one included, lands in the cycle after its issue.
         rd_v_ff <= cmd.rd_issue;
         if (st_ff) begin
            icol_ff  <= ic_n;
            irow_ff  <= ir_n;
            done_ff  <= done_c;
            waddr_ff <= waddr_in;
         end
         if (cmd.finish) begin
            ocol_ff <= ocol_in;
            orow_ff <= orow_in;
            if (last_ff) begin
               icol_ff <= '0; irow_ff <= '0; done_ff <= 1'b0;
               waddr_ff <= '0; obase_ff <= '0;
            end else if (ocol_in == '0) begin
               obase_ff <= wrap(PW'(obase_ff) + PW'(wcol));
            end
         end
      end
   end

   always_comb begin
      ocol_in = ocol_ff + CW'(1);
      orow_in = orow_ff;
      if (ocol_in >= wcol) begin
         ocol_in = '0;
         orow_in = orow_ff + RW'(1);
      end
      if (last_ff) begin
         ocol_in = '0;
         orow_in = '0;
      end
   end

   // Window sweep: one pixel read per cycle.
   logic sweep_end;
   assign sweep_end = (x_ff >= x1_ff) && (y_ff >= y1_ff);
   always_ff @(posedge clock) begin
      if (cmd.clr_acc) begin
         x0_ff <= x0_c; x1_ff <= x1_c; y1_ff <= y1_c;
         x_ff <= x0_c; y_ff <= y0_c;
         rowbase_ff <= rb_c;
         addr_ff <= wrap(PW'(rb_c) + PW'(x0_c));
         sr_ff <= '0; sg_ff <= '0; sb_ff <= '0; cnt_ff <= '0;
         last_ff <= ((ocol_ff + CW'(1)) >= wcol) && ((orow_ff + RW'(1)) >= hrow);
      end else begin
         if (cmd.rd_issue && !sweep_end) begin
            if (x_ff >= x1_ff) begin
               x_ff       <= x0_ff;
               y_ff       <= y_ff + (RW+1)'(1);
               rowbase_ff <= wrap(PW'(rowbase_ff) + PW'(wcol));
               addr_ff    <= wrap(PW'(wrap(PW'(rowbase_ff) + PW'(wcol))) + PW'(x0_ff));
            end else begin
               x_ff    <= x_ff + (CW+1)'(1);
               addr_ff <= next_addr;
            end
         end
         if (cmd.acc_en && rd_v_ff) begin
            sr_ff  <= sr_ff + SW'(rd_ff[23:16]);
            sg_ff  <= sg_ff + SW'(rd_ff[15:8]);
            sb_ff  <= sb_ff + SW'(rd_ff[7:0]);
            cnt_ff <= cnt_ff + KW'(1);
         end
      end
   end

   // Empty window only after mid-frame size changes.
   logic empty_ff;
   always_ff @(posedge clock) begin
      if (cmd.clr_acc) empty_ff <= (x0_c > x1_c) || (y0_c > y1_c);
   end

   bbce_div #(.NW(SW), .DW(KW)) u_div_r (.clock, .reset, .start(cmd.div_start),
      .num(sr_ff), .den(cnt_ff), .quo(q0), .done(d0));
   bbce_div #(.NW(SW), .DW(KW)) u_div_g (.clock, .reset, .start(cmd.div_start),
      .num(sg_ff), .den(cnt_ff), .quo(q1), .done(d1));
   bbce_div #(.NW(SW), .DW(KW)) u_div_b (.clock, .reset, .start(cmd.div_start),
      .num(sb_ff), .den(cnt_ff), .quo(q2), .done(d2));

   assign qr = (empty_ff || cnt_ff == '0) ? 8'd0 : q0[7:0];
   assign qg = (empty_ff || cnt_ff == '0) ? 8'd0 : q1[7:0];
   assign qb = (empty_ff || cnt_ff == '0) ? 8'd0 : q2[7:0];

   logic [24:0] rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.finish) rsp_ff <= {last_ff, qb, qg, qr};
   end
   assign rsp_data = rsp_ff;

   // The emit decision is taken in the cycle after the start beat, from the
   // counters as they stand after this beat's bookkeeping.
   assign sts.emit     = emit_c;
   assign sts.win_done = sweep_end || empty_ff;
   assign sts.div_done = d0 && d1 && d2;
endmodule
`default_nettype wire

FILE: hw/rtl/box_blur_clipped_edges.sv
// Box blur with clipped edges, RGB888 raster stream in and out.
// An accepted input beat is decoded; if it releases a result, the clipped window of N
// pixels (1 to 225) is read and summed, divided, and then rsp_tvalid rises.
// Beats are taken one at a time; a beat that emits nothing ends after decode, one that
// emits ends after sweep, divide and any wait for the previous result to leave.
// Reset: synchronous, active high; counters clear, line storage stays undefined.
`timescale 1ns / 1ps
`default_nettype none
module box_blur_clipped_edges #(
   parameter int MAX_RADIUS = bbce_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = bbce_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bbce_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // in_red, in_green, in_blue
   input  wire logic        req_tuser,  // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // out_red, out_green, out_blue
   output logic             rsp_tlast,  // frame_end
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   // The configuration registers hold the low bits of each write, clamped to the maximum.
   logic [4:0]  radius_ff;
   logic [13:0] width_ff;
   logic [14:0] height_ff;
   logic        wr;
   logic [1:0]  idx;
   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 5'd1;
         width_ff  <= 14'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
         height_ff <= 15'(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024);
      end else if (wr) begin
         case (idx)
            bbce_pkg::REG_RADIUS: begin
               radius_ff <= (32'(csr_pwdata[2:0]) > 32'(MAX_RADIUS)) ? 5'(MAX_RADIUS)
                            : 5'(csr_pwdata[2:0]);
            end
            bbce_pkg::REG_WIDTH: begin
               if (csr_pwdata[10:0] == 11'd0) width_ff <= 14'd1;
               else if (32'(csr_pwdata[10:0]) > 32'(MAX_WIDTH)) width_ff <= 14'(MAX_WIDTH);
               else width_ff <= 14'(csr_pwdata[10:0]);
            end
            bbce_pkg::REG_HEIGHT: begin
               if (csr_pwdata[12:0] == 13'd0) height_ff <= 15'd1;
               else if (32'(csr_pwdata[12:0]) > 32'(MAX_HEIGHT)) height_ff <= 15'(MAX_HEIGHT);
               else height_ff <= 15'(csr_pwdata[12:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         bbce_pkg::REG_RADIUS: csr_prdata = 32'(radius_ff);
         bbce_pkg::REG_WIDTH:  csr_prdata = 32'(width_ff);
         bbce_pkg::REG_HEIGHT: csr_prdata = 32'(height_ff);
         default:              csr_prdata = '0;
      endcase
   end

   bbce_pkg::cmd_type cmd;
   bbce_pkg::sts_type sts;
   logic [24:0]       data;

   bbce_ctrl u_ctrl (.clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid,
      .rsp_tready, .cmd, .sts);

   bbce_datapath #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)) u_dp (.clock, .reset, .cmd, .sts,
      .in_op(req_tuser), .in_px({req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]}),
      .radius(radius_ff), .width(width_ff), .height(height_ff), .rsp_data(data));

   assign rsp_tdata = data[23:0];
   assign rsp_tlast = data[24];
endmodule
`default_nettype wire
